// ===== rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants and the arctangent table for the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;

    // Rotation-based arctangent: step count and angle accumulator format.
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int ACC_FRAC     = 24;
    localparam int ACC_W        = 34;
    localparam int ARG_W        = 32;
    localparam int CORDIC_W     = 35;

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sd1509949440;

    // atan(2^-i) in units of 2^-24 degree, rounded to nearest.
    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115,
        34'sd57,        34'sd29,        34'sd14,        34'sd7
    };

endpackage

// ===== rtl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring-mode arctangent: a quarter-turn pre-rotation stage
// followed by one register stage per micro-rotation.
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::ARG_W-1:0]  y_in,
    input  logic signed [qte_pkg::ARG_W-1:0]  x_in,
    output logic signed [qte_pkg::ACC_W-1:0]  acc_out
);
    import qte_pkg::*;

    logic signed [CORDIC_W-1:0] x_ext;
    logic signed [CORDIC_W-1:0] y_ext;
    logic signed [CORDIC_W-1:0] x_pre;
    logic signed [CORDIC_W-1:0] y_pre;
    logic signed [ACC_W-1:0]    acc_pre;
    logic                       hold_pre;

    logic signed [CORDIC_W-1:0] x_reg   [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg   [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0]    acc_reg [CORDIC_STEPS+1];
    logic                       hold_reg [CORDIC_STEPS+1];

    // Bring the vector into the right half-plane; a null vector or one
    // already on the axis needs no micro-rotations.
    always_comb
    begin
        x_ext   = CORDIC_W'(x_in);
        y_ext   = CORDIC_W'(y_in);
        x_pre   = x_ext;
        y_pre   = y_ext;
        acc_pre = '0;
        if (x_ext < 0)
        begin
            if (y_ext >= 0)
            begin
                x_pre   = y_ext;
                y_pre   = -x_ext;
                acc_pre = QUARTER_TURN;
            end
            else
            begin
                x_pre   = -y_ext;
                y_pre   = x_ext;
                acc_pre = -QUARTER_TURN;
            end
        end
        hold_pre = (y_pre == 0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            acc_reg[0]  <= acc_pre;
            hold_reg[0] <= hold_pre;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                hold_reg[i+1] <= hold_reg[i];
                if (hold_reg[i])
                begin
                    x_reg[i+1]   <= x_reg[i];
                    y_reg[i+1]   <= y_reg[i];
                    acc_reg[i+1] <= acc_reg[i];
                end
                else if (y_reg[i] > 0)
                begin
                    x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                    acc_reg[i+1] <= acc_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign acc_out = acc_reg[CORDIC_STEPS];

endmodule

// ===== rtl/quaternion_to_euler_xyz.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_xyz
// Throughput: one word per cycle unless a held result word stalls the
// pipeline; the 30-stage square root and the 29-stage arctangent
// pipelines set the depth, not the rate.
// Reset clears only the valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_xyz #(
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic signed [15:0] qz,
    input  logic signed [15:0] qw,
    input  logic               not_finite,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] angle_x,
    output logic signed [14:0] angle_y,
    output logic signed [15:0] angle_z
);
    import qte_pkg::*;

    localparam int N2_W     = 33;
    localparam int T_W      = 35;
    localparam int MAG_W    = 34;
    localparam int U_W      = 30;
    localparam int ROOT_W   = 30;
    localparam int RAD_W    = 60;
    localparam int TRIAL_W  = 62;
    localparam int LOCK_W   = 52;
    localparam int SQ_STEPS = ROOT_W;
    localparam int NORM_MSB = 29;
    localparam int PIPE_LEN = 6 + SQ_STEPS + CORDIC_LAT;
    localparam int N_TERMS  = 7;

    localparam int TI_20 = 0;
    localparam int TI_21 = 1;
    localparam int TI_22 = 2;
    localparam int TI_10 = 3;
    localparam int TI_00 = 4;
    localparam int TI_12 = 5;
    localparam int TI_11 = 6;

    localparam logic [16:0] LOCK_NUM = 17'd100000;
    localparam logic [16:0] LOCK_DEN = 17'd99999;

    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SH - 1);
    localparam logic [ACC_W-1:0] LIM_XZ   = ACC_W'(180) << ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] LIM_Y    = ACC_W'(90) << ANGLE_FRAC_BITS;

    typedef struct packed {
        logic                    force0;
        logic                    lock;
        logic signed [ARG_W-1:0] y_y;
        logic signed [ARG_W-1:0] x_y;
        logic signed [ARG_W-1:0] x_x;
        logic signed [ARG_W-1:0] z_y;
        logic signed [ARG_W-1:0] z_x;
    } side_t;

    function automatic logic [ARG_W-2:0] scale_mag(input logic [MAG_W-1:0] m,
                                                   input logic             left,
                                                   input logic [4:0]       amt);
        logic [63:0] wide;
        wide = left ? (64'(m) << amt) : (64'(m) >> amt);
        return wide[ARG_W-2:0];
    endfunction

    function automatic logic signed [ARG_W-1:0] to_arg(input logic [ARG_W-2:0] m,
                                                       input logic             neg);
        logic signed [ARG_W-1:0] v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [ACC_W-1:0] finish_angle(
        input logic signed [ACC_W-1:0] a,
        input logic [ACC_W-1:0]        lim
    );
        logic [ACC_W-1:0] m;
        m = (a < 0) ? ACC_W'(-a) : ACC_W'(a);
        m = (m + RND_HALF) >> RND_SH;
        if (m > lim)
        begin
            m = lim;
        end
        return (a < 0) ? -$signed(m) : $signed(m);
    endfunction

    logic adv;
    logic [PIPE_LEN-1:0] v_reg;
    logic result_valid_reg;

    assign adv        = !(result_valid_reg && result_stall);
    assign item_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg            <= {v_reg[PIPE_LEN-2:0], item_valid};
            result_valid_reg <= v_reg[PIPE_LEN-1];
        end
    end

    // Stage 1: the ten component products.
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg, xz_reg;
    logic signed [31:0] wy_reg, yz_reg, wx_reg, xy_reg, wz_reg;
    logic               nf1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg  <= qx * qx;
            yy_reg  <= qy * qy;
            zz_reg  <= qz * qz;
            ww_reg  <= qw * qw;
            xz_reg  <= qx * qz;
            wy_reg  <= qw * qy;
            yz_reg  <= qy * qz;
            wx_reg  <= qw * qx;
            xy_reg  <= qx * qy;
            wz_reg  <= qw * qz;
            nf1_reg <= not_finite;
        end
    end

    // Stage 2: squared norm and the unnormalised matrix terms.
    logic signed [T_W-1:0] sum_n2;
    logic signed [T_W-1:0] t_next [N_TERMS];
    logic signed [T_W-1:0] t2_reg [N_TERMS];
    logic [N2_W-1:0]       n2_2_reg;
    logic                  f2_reg;

    always_comb
    begin
        sum_n2 = T_W'(xx_reg) + T_W'(yy_reg) + T_W'(zz_reg) + T_W'(ww_reg);
        t_next[TI_20] = (T_W'(xz_reg) - T_W'(wy_reg)) <<< 1;
        t_next[TI_21] = (T_W'(yz_reg) + T_W'(wx_reg)) <<< 1;
        t_next[TI_22] = sum_n2 - ((T_W'(xx_reg) + T_W'(yy_reg)) <<< 1);
        t_next[TI_10] = (T_W'(xy_reg) + T_W'(wz_reg)) <<< 1;
        t_next[TI_00] = sum_n2 - ((T_W'(yy_reg) + T_W'(zz_reg)) <<< 1);
        t_next[TI_12] = (T_W'(yz_reg) - T_W'(wx_reg)) <<< 1;
        t_next[TI_11] = sum_n2 - ((T_W'(xx_reg) + T_W'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg   <= t_next;
            n2_2_reg <= N2_W'(sum_n2);
            f2_reg   <= nf1_reg || (sum_n2 == 0);
        end
    end

    // Stage 3: gimbal-lock test, sign and magnitude split, leading one of
    // the norm.
    logic [MAG_W-1:0] mag_c [N_TERMS];
    logic             neg_c [N_TERMS];
    logic             lock_c;
    logic [5:0]       msb_c;
    logic             left_c;
    logic [4:0]       amt_c;

    logic [MAG_W-1:0] mag3_reg [N_TERMS];
    logic             neg3_reg [N_TERMS];
    logic [N2_W-1:0]  n2_3_reg;
    logic             lock3_reg;
    logic             f3_reg;
    logic             left3_reg;
    logic [4:0]       amt3_reg;

    always_comb
    begin
        for (int k = 0; k < N_TERMS; k++)
        begin
            neg_c[k] = (t2_reg[k] < 0);
            mag_c[k] = neg_c[k] ? MAG_W'(-t2_reg[k]) : MAG_W'(t2_reg[k]);
        end
        lock_c = !((LOCK_W'(mag_c[TI_20]) * LOCK_W'(LOCK_NUM)) <
                   (LOCK_W'(n2_2_reg) * LOCK_W'(LOCK_DEN)));
        msb_c = '0;
        for (int b = 0; b < N2_W; b++)
        begin
            if (n2_2_reg[b])
            begin
                msb_c = 6'(b);
            end
        end
        left_c = (msb_c <= 6'(NORM_MSB));
        amt_c  = left_c ? 5'(6'(NORM_MSB) - msb_c) : 5'(msb_c - 6'(NORM_MSB));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag3_reg  <= mag_c;
            neg3_reg  <= neg_c;
            n2_3_reg  <= n2_2_reg;
            lock3_reg <= lock_c;
            f3_reg    <= f2_reg;
            left3_reg <= left_c;
            amt3_reg  <= amt_c;
        end
    end

    // Stage 4: scale everything so that the norm lies in [2^29, 2^30) and
    // pick the arctangent arguments.
    logic [ARG_W-2:0] s_c [N_TERMS];
    logic [ARG_W-2:0] n2s_c;
    logic [U_W-1:0]   n2u_c;
    logic [U_W-1:0]   a20_c;
    side_t            side_c;

    logic [U_W-1:0]   n2u_reg;
    logic [U_W-1:0]   a20_reg;
    side_t            side4_reg;

    always_comb
    begin
        for (int k = 0; k < N_TERMS; k++)
        begin
            s_c[k] = scale_mag(mag3_reg[k], left3_reg, amt3_reg);
        end
        n2s_c = scale_mag(MAG_W'(n2_3_reg), left3_reg, amt3_reg);
        n2u_c = n2s_c[U_W-1:0];
        if (s_c[TI_20] > {1'b0, n2u_c})
        begin
            a20_c = n2u_c;
        end
        else
        begin
            a20_c = s_c[TI_20][U_W-1:0];
        end
        side_c.force0 = f3_reg;
        side_c.lock   = lock3_reg;
        side_c.y_y    = to_arg({1'b0, a20_c}, !neg3_reg[TI_20]);
        if (lock3_reg)
        begin
            side_c.x_y = to_arg(s_c[TI_12], !neg3_reg[TI_12]);
            side_c.x_x = to_arg(s_c[TI_11], neg3_reg[TI_11]);
        end
        else
        begin
            side_c.x_y = to_arg(s_c[TI_21], neg3_reg[TI_21]);
            side_c.x_x = to_arg(s_c[TI_22], neg3_reg[TI_22]);
        end
        side_c.z_y = to_arg(s_c[TI_10], neg3_reg[TI_10]);
        side_c.z_x = to_arg(s_c[TI_00], neg3_reg[TI_00]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n2u_reg   <= n2u_c;
            a20_reg   <= a20_c;
            side4_reg <= side_c;
        end
    end

    // Stages 5 and 6: radicand n2^2 - m20^2, i.e. (cos Y * n2)^2.
    logic [RAD_W-1:0] sqn_reg;
    logic [RAD_W-1:0] sqa_reg;
    logic [RAD_W-1:0] rad_reg;
    side_t            side5_reg;
    side_t            side6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqn_reg   <= RAD_W'(n2u_reg) * RAD_W'(n2u_reg);
            sqa_reg   <= RAD_W'(a20_reg) * RAD_W'(a20_reg);
            side5_reg <= side4_reg;
            rad_reg   <= sqn_reg - sqa_reg;
            side6_reg <= side5_reg;
        end
    end

    // Square root, one result bit per stage, most significant first.
    logic [RAD_W-1:0]   rem_in   [SQ_STEPS];
    logic [ROOT_W-1:0]  root_in  [SQ_STEPS];
    logic [TRIAL_W-1:0] trial    [SQ_STEPS];
    logic               take     [SQ_STEPS];
    logic [RAD_W-1:0]   rem_nx   [SQ_STEPS];
    logic [ROOT_W-1:0]  root_nx  [SQ_STEPS];

    logic [RAD_W-1:0]   rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0]  root_reg [SQ_STEPS];
    side_t              sside_reg [SQ_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k]  = rad_reg;
                root_in[k] = '0;
            end
            else
            begin
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            trial[k] = (TRIAL_W'(root_in[k]) << (ROOT_W - k)) +
                       (TRIAL_W'(1) << (2 * (ROOT_W - 1 - k)));
            take[k]  = (TRIAL_W'(rem_in[k]) >= trial[k]);
            rem_nx[k]  = take[k] ? RAD_W'(TRIAL_W'(rem_in[k]) - trial[k]) : rem_in[k];
            root_nx[k] = take[k] ? (root_in[k] | (ROOT_W'(1) << (ROOT_W - 1 - k)))
                                 : root_in[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem_reg[k]  <= rem_nx[k];
                root_reg[k] <= root_nx[k];
                if (k == 0)
                begin
                    sside_reg[k] <= side6_reg;
                end
                else
                begin
                    sside_reg[k] <= sside_reg[k-1];
                end
            end
        end
    end

    // Three arctangent pipelines side by side.
    side_t                   side_q;
    logic signed [ARG_W-1:0] cy_arg;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic [1:0]              cf_reg [CORDIC_LAT];

    assign side_q = sside_reg[SQ_STEPS-1];
    assign cy_arg = $signed({{(ARG_W-ROOT_W){1'b0}}, root_reg[SQ_STEPS-1]});

    qte_cordic u_cordic_x (
        .clk     (clk),
        .en      (adv),
        .y_in    (side_q.x_y),
        .x_in    (side_q.x_x),
        .acc_out (acc_x)
    );

    qte_cordic u_cordic_y (
        .clk     (clk),
        .en      (adv),
        .y_in    (side_q.y_y),
        .x_in    (cy_arg),
        .acc_out (acc_y)
    );

    qte_cordic u_cordic_z (
        .clk     (clk),
        .en      (adv),
        .y_in    (side_q.z_y),
        .x_in    (side_q.z_x),
        .acc_out (acc_z)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < CORDIC_LAT; k++)
            begin
                if (k == 0)
                begin
                    cf_reg[k] <= {side_q.force0, side_q.lock};
                end
                else
                begin
                    cf_reg[k] <= cf_reg[k-1];
                end
            end
        end
    end

    // Output register: round, saturate and apply the special cases.
    logic signed [ACC_W-1:0] fx_c;
    logic signed [ACC_W-1:0] fy_c;
    logic signed [ACC_W-1:0] fz_c;
    logic                    force0_c;
    logic                    lock_o;

    logic signed [15:0] angle_x_reg;
    logic signed [14:0] angle_y_reg;
    logic signed [15:0] angle_z_reg;

    always_comb
    begin
        force0_c = cf_reg[CORDIC_LAT-1][1];
        lock_o   = cf_reg[CORDIC_LAT-1][0];
        fx_c     = finish_angle(acc_x, LIM_XZ);
        fy_c     = finish_angle(acc_y, LIM_Y);
        fz_c     = finish_angle(acc_z, LIM_XZ);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_x_reg <= force0_c ? '0 : fx_c[15:0];
            angle_y_reg <= force0_c ? '0 : fy_c[14:0];
            angle_z_reg <= (force0_c || lock_o) ? '0 : fz_c[15:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign angle_x      = angle_x_reg;
    assign angle_y      = angle_y_reg;
    assign angle_z      = angle_z_reg;

endmodule

// ===== rtl/qte_checker.sv =====
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the quaternion to Euler angle block, bound to the
// top level.
// ----------------------------------------------------------------------------
module qte_checker #(
    parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [15:0] angle_x,
    input logic signed [14:0] angle_y,
    input logic signed [15:0] angle_z
);
    localparam int LIM_Y = 90 << ANGLE_FRAC_BITS;

    // A held result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(angle_x) && $stable(angle_y) && $stable(angle_z))
        else $error("result word changed while stalled");

    // The pipeline only freezes when the output word is held back.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("input stall does not follow the output hold");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (ANGLE_FRAC_BITS > 7) ||
            (($signed(angle_y) <= LIM_Y) && ($signed(angle_y) >= -LIM_Y)))
        else $error("Y angle outside a quarter turn");

endmodule

bind quaternion_to_euler_xyz qte_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_qte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .angle_x      (angle_x),
    .angle_y      (angle_y),
    .angle_z      (angle_z)
);
